FILE: hw/rtl/directory_slot_first_fit_search_assert.svh
// Assertion macros for the directory slot search block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef DIRECTORY_SLOT_FIRST_FIT_SEARCH_ASSERT_SVH
`define DIRECTORY_SLOT_FIRST_FIT_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define DSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dss_pkg.sv
// Shared types and constants for the directory slot search block.
// No dependencies; used by the top level.
package dss_pkg;

    // Entry type codes.
    localparam logic [15:0] TYPE_FREE = 16'h0000;
    localparam logic [15:0] TYPE_END  = 16'hFFFF;

    // Directory entries held by one directory sector, as a shift amount.
    localparam int unsigned ENTRY_SHIFT = 3;

    // Result outcomes.
    typedef enum logic [2:0] {
        OUTCOME_REUSE     = 3'd0,
        OUTCOME_FREE      = 3'd1,
        OUTCOME_APPEND    = 3'd2,
        OUTCOME_DIR_FULL  = 3'd3,
        OUTCOME_DATA_FULL = 3'd4
    } outcome_t;

    // Configuration register indexes (byte address / 8).
    localparam logic [2:0] REG_NEEDED_LENGTH      = 3'd0;
    localparam logic [2:0] REG_NAME_HEAD          = 3'd1;
    localparam logic [2:0] REG_NAME_TAIL          = 3'd2;
    localparam logic [2:0] REG_DIRECTORY_START    = 3'd3;
    localparam logic [2:0] REG_DIRECTORY_SECTORS  = 3'd4;
    localparam logic [2:0] REG_TRACKS_PER_SURFACE = 3'd5;
    localparam logic [2:0] REG_SURFACE_COUNT      = 3'd6;
    localparam logic [2:0] REG_SECTORS_PER_TRACK  = 3'd7;

    // Configuration reset values.
    localparam logic [15:0] NAME_TAIL_RESET         = 16'h2020;
    localparam logic [31:0] DIRECTORY_START_RESET   = 32'd2;
    localparam logic [12:0] DIRECTORY_SECTORS_RESET = 13'd1;

    // A result waiting for the data-area check and the output register.
    typedef struct packed {
        outcome_t    kind;
        logic [15:0] slot_index;
        logic [31:0] start_sector;
        logic        purge_old;
        logic [15:0] old_index;
        logic [32:0] last_end;
    } pend_t;

endpackage

FILE: hw/rtl/dss_if.sv
// Valid/ready channel interfaces for directory entries and search results.
// Depends on nothing; the top level uses both.
interface dss_entry_if;
    logic        valid;
    logic        ready;
    logic [15:0] entry_type;
    logic [31:0] entry_start;
    logic [31:0] entry_length;
    logic [63:0] entry_name_head;
    logic [15:0] entry_name_tail;

    modport source (
        output valid, entry_type, entry_start, entry_length, entry_name_head,
               entry_name_tail,
        input  ready
    );
    modport sink (
        input  valid, entry_type, entry_start, entry_length, entry_name_head,
               entry_name_tail,
        output ready
    );
endinterface

interface dss_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic [15:0] slot_index;
    logic [31:0] start_sector;
    logic        purge_old;
    logic [15:0] old_index;
    logic        new_end_marker;

    modport source (
        output valid, outcome, slot_index, start_sector, purge_old, old_index,
               new_end_marker,
        input  ready
    );
    modport sink (
        input  valid, outcome, slot_index, start_sector, purge_old, old_index,
               new_end_marker,
        output ready
    );
endinterface

FILE: hw/rtl/directory_slot_first_fit_search.sv
// First-fit directory slot search. Directory entries arrive one per transfer, and
// one entry can be accepted every clock while the pending and output stages have
// room. An entry is captured in an input register, scanned against the running
// scan state, and a finished scan moves to a pending stage where the data
// area size (a 32x16 product of a registered partial product) is checked before
// the output register. A result passes through the input, pending and output
// registers after the transfer of the entry that ends the scan; the scan loop
// state update sets the throughput. A scan ends at an end marker or at the
// entry limit (eight entries per directory sector). Depends on dss_pkg, dss_if
// and the assertion macro header.
module directory_slot_first_fit_search
    import dss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Channels.
    dss_entry_if.sink    entry,
    dss_result_if.source result
);

    // Configuration registers.
    logic [31:0] needed_length_reg;
    logic [63:0] name_head_reg;
    logic [15:0] name_tail_reg;
    logic [31:0] directory_start_reg;
    logic [12:0] directory_sectors_reg;
    logic [15:0] tracks_per_surface_reg;
    logic [15:0] surface_count_reg;
    logic [15:0] sectors_per_track_reg;
    logic [31:0] surface_product_reg;

    // Input stage.
    logic        in_valid_reg;
    logic [15:0] in_type_reg;
    logic [31:0] in_start_reg;
    logic [31:0] in_length_reg;
    logic [63:0] in_name_head_reg;
    logic [15:0] in_name_tail_reg;

    // Scan state.
    logic [15:0] seen_reg;
    logic        free_found_reg;
    logic [15:0] free_index_reg;
    logic [31:0] free_start_reg;
    logic        match_found_reg;
    logic [15:0] match_index_reg;
    logic [31:0] match_start_reg;
    logic [31:0] match_length_reg;
    logic [32:0] last_end_reg;

    // Pending and output stages.
    logic        pend_valid_reg;
    pend_t       pend_reg;
    logic        out_valid_reg;
    outcome_t    out_outcome_reg;
    logic [15:0] out_slot_index_reg;
    logic [31:0] out_start_sector_reg;
    logic        out_purge_old_reg;
    logic [15:0] out_old_index_reg;
    logic        out_new_end_marker_reg;

    logic        cfg_write;
    logic        out_load;
    logic        pend_free;
    logic        scan_fire;
    logic        in_load;

    logic [15:0] limit;
    logic [32:0] scan_base;
    logic [32:0] last_end_view;
    logic        pre_done;
    logic        at_marker;
    logic        step_update;
    logic        free_take;
    logic        name_hit;
    logic [15:0] seen_inc;
    logic        post_done;
    logic        scan_result;

    logic        v_free_found;
    logic [15:0] v_free_index;
    logic [31:0] v_free_start;
    logic        v_match_found;
    logic [15:0] v_match_index;
    logic [31:0] v_match_start;
    logic [31:0] v_match_length;
    pend_t       pend_next;

    logic [33:0] append_end;
    logic [47:0] data_capacity;
    logic        data_full;

    // Configuration write and read.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        case (paddr[5:3])
            REG_NEEDED_LENGTH:      prdata = {32'b0, needed_length_reg};
            REG_NAME_HEAD:          prdata = name_head_reg;
            REG_NAME_TAIL:          prdata = {48'b0, name_tail_reg};
            REG_DIRECTORY_START:    prdata = {32'b0, directory_start_reg};
            REG_DIRECTORY_SECTORS:  prdata = {51'b0, directory_sectors_reg};
            REG_TRACKS_PER_SURFACE: prdata = {48'b0, tracks_per_surface_reg};
            REG_SURFACE_COUNT:      prdata = {48'b0, surface_count_reg};
            REG_SECTORS_PER_TRACK:  prdata = {48'b0, sectors_per_track_reg};
            default:                prdata = 64'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_length_reg      <= 32'b0;
            name_head_reg          <= 64'b0;
            name_tail_reg          <= NAME_TAIL_RESET;
            directory_start_reg    <= DIRECTORY_START_RESET;
            directory_sectors_reg  <= DIRECTORY_SECTORS_RESET;
            tracks_per_surface_reg <= 16'b0;
            surface_count_reg      <= 16'b0;
            sectors_per_track_reg  <= 16'b0;
            surface_product_reg    <= 32'b0;
        end
        else
        begin
            // The first factor of the data area size, registered from the tracks and surface registers.
            surface_product_reg <= {16'b0, tracks_per_surface_reg} * {16'b0, surface_count_reg};
            if (cfg_write)
            begin
                case (paddr[5:3])
                    REG_NEEDED_LENGTH:      needed_length_reg      <= pwdata[31:0];
                    REG_NAME_HEAD:          name_head_reg          <= pwdata;
                    REG_NAME_TAIL:          name_tail_reg          <= pwdata[15:0];
                    REG_DIRECTORY_START:    directory_start_reg    <= pwdata[31:0];
                    REG_DIRECTORY_SECTORS:  directory_sectors_reg  <= pwdata[12:0];
                    REG_TRACKS_PER_SURFACE: tracks_per_surface_reg <= pwdata[15:0];
                    REG_SURFACE_COUNT:      surface_count_reg      <= pwdata[15:0];
                    REG_SECTORS_PER_TRACK:  sectors_per_track_reg  <= pwdata[15:0];
                    default:                needed_length_reg      <= needed_length_reg;
                endcase
            end
        end
    end

    // Pipeline flow: each stage moves when the stage after it has room.
    assign out_load    = pend_valid_reg && (!out_valid_reg || result.ready);
    assign pend_free   = !pend_valid_reg || out_load;
    assign scan_fire   = in_valid_reg && pend_free;
    assign entry.ready = !in_valid_reg || scan_fire;
    assign in_load     = entry.valid && entry.ready;

    // Scan step: limit checks, marker detection and slot tracking.
    assign limit         = {directory_sectors_reg, ENTRY_SHIFT'(0)};
    assign scan_base     = {1'b0, directory_start_reg} + {20'b0, directory_sectors_reg};
    assign last_end_view = (seen_reg == 16'b0) ? scan_base : last_end_reg;
    assign pre_done      = seen_reg >= limit;
    assign at_marker     = !pre_done && (in_type_reg == TYPE_END);
    assign step_update   = !pre_done && (in_type_reg != TYPE_END);
    assign free_take     = (in_type_reg == TYPE_FREE) && (in_length_reg >= needed_length_reg)
                           && !free_found_reg;
    assign name_hit      = (in_name_head_reg == name_head_reg)
                           && (in_name_tail_reg == name_tail_reg);
    assign seen_inc      = seen_reg + 16'd1;
    assign post_done     = step_update && (seen_inc >= limit);
    assign scan_result   = pre_done || at_marker || post_done;

    // Slot state as the result sees it: after this entry when the limit is hit on it.
    always_comb
    begin
        v_free_found   = free_found_reg;
        v_free_index   = free_index_reg;
        v_free_start   = free_start_reg;
        v_match_found  = match_found_reg;
        v_match_index  = match_index_reg;
        v_match_start  = match_start_reg;
        v_match_length = match_length_reg;
        if (post_done)
        begin
            if (free_take)
            begin
                v_free_found = 1'b1;
                v_free_index = seen_reg;
                v_free_start = in_start_reg;
            end
            else if (name_hit)
            begin
                v_match_found  = 1'b1;
                v_match_index  = seen_reg;
                v_match_start  = in_start_reg;
                v_match_length = in_length_reg;
            end
        end
    end

    // Outcome choice; the data area check waits for the pending stage.
    always_comb
    begin
        pend_next              = '0;
        pend_next.kind         = OUTCOME_DIR_FULL;
        pend_next.last_end     = last_end_view;
        if (v_match_found && (v_match_length >= needed_length_reg))
        begin
            pend_next.kind         = OUTCOME_REUSE;
            pend_next.slot_index   = v_match_index;
            pend_next.start_sector = v_match_start;
        end
        else if (v_free_found)
        begin
            pend_next.kind         = OUTCOME_FREE;
            pend_next.slot_index   = v_free_index;
            pend_next.start_sector = v_free_start;
            pend_next.purge_old    = v_match_found;
            pend_next.old_index    = v_match_found ? v_match_index : 16'b0;
        end
        else if (at_marker)
        begin
            pend_next.kind         = OUTCOME_APPEND;
            pend_next.slot_index   = seen_reg;
            pend_next.start_sector = last_end_view[31:0];
            pend_next.purge_old    = v_match_found;
            pend_next.old_index    = v_match_found ? v_match_index : 16'b0;
        end
    end

    // Input register, scan control state and the pending and output valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            seen_reg        <= 16'b0;
            free_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (scan_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (scan_fire)
            begin
                if (scan_result)
                begin
                    seen_reg        <= 16'b0;
                    free_found_reg  <= 1'b0;
                    match_found_reg <= 1'b0;
                end
                else if (step_update)
                begin
                    seen_reg <= seen_inc;
                    if (free_take)
                    begin
                        free_found_reg <= 1'b1;
                    end
                    else if (name_hit)
                    begin
                        match_found_reg <= 1'b1;
                    end
                end
            end

            if (scan_fire)
            begin
                pend_valid_reg <= scan_result;
            end
            else if (out_load)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the input, scan and pending stages.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_type_reg      <= entry.entry_type;
            in_start_reg     <= entry.entry_start;
            in_length_reg    <= entry.entry_length;
            in_name_head_reg <= entry.entry_name_head;
            in_name_tail_reg <= entry.entry_name_tail;
        end
        if (scan_fire && step_update)
        begin
            last_end_reg <= {1'b0, in_start_reg} + {1'b0, in_length_reg};
            if (free_take)
            begin
                free_index_reg <= seen_reg;
                free_start_reg <= in_start_reg;
            end
            else if (name_hit)
            begin
                match_index_reg  <= seen_reg;
                match_start_reg  <= in_start_reg;
                match_length_reg <= in_length_reg;
            end
        end
        if (scan_fire && scan_result)
        begin
            pend_reg <= pend_next;
        end
    end

    // Data area check for an append.
    assign append_end    = {1'b0, pend_reg.last_end} + {2'b0, needed_length_reg};
    assign data_capacity = {16'b0, surface_product_reg} * {32'b0, sectors_per_track_reg};
    assign data_full     = pend_reg.last_end[32] || ({14'b0, append_end} >= data_capacity);

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if ((pend_reg.kind == OUTCOME_APPEND) && data_full)
            begin
                out_outcome_reg        <= OUTCOME_DATA_FULL;
                out_slot_index_reg     <= 16'b0;
                out_start_sector_reg   <= 32'b0;
                out_purge_old_reg      <= 1'b0;
                out_old_index_reg      <= 16'b0;
                out_new_end_marker_reg <= 1'b0;
            end
            else
            begin
                out_outcome_reg        <= pend_reg.kind;
                out_slot_index_reg     <= pend_reg.slot_index;
                out_start_sector_reg   <= pend_reg.start_sector;
                out_purge_old_reg      <= pend_reg.purge_old;
                out_old_index_reg      <= pend_reg.old_index;
                out_new_end_marker_reg <= (pend_reg.kind == OUTCOME_APPEND);
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.outcome        = out_outcome_reg;
    assign result.slot_index     = out_slot_index_reg;
    assign result.start_sector   = out_start_sector_reg;
    assign result.purge_old      = out_purge_old_reg;
    assign result.old_index      = out_old_index_reg;
    assign result.new_end_marker = out_new_end_marker_reg;

`include "directory_slot_first_fit_search_assert.svh"

    // A full directory or data area carries no slot information.
    `DSS_ASSERT_NOW(a_full_fields_zero,
        result.valid && (result.outcome == OUTCOME_DIR_FULL
                         || result.outcome == OUTCOME_DATA_FULL),
        result.slot_index == 16'b0 && result.start_sector == 32'b0 && !result.purge_old
            && result.old_index == 16'b0 && !result.new_end_marker,
        "full outcome with nonzero fields")

    // Only an append writes a new end marker.
    `DSS_ASSERT_NOW(a_marker_only_append,
        result.valid && result.new_end_marker,
        result.outcome == OUTCOME_APPEND,
        "end marker without append")

    // Reusing the old entry never purges it.
    `DSS_ASSERT_NOW(a_reuse_no_purge,
        result.valid && result.outcome == OUTCOME_REUSE,
        !result.purge_old,
        "reuse outcome requests a purge")

    // A scan that ends clears the slot tracking for the next scan.
    `DSS_ASSERT_NEXT(a_scan_clears,
        scan_fire && scan_result,
        seen_reg == 16'b0 && !free_found_reg && !match_found_reg,
        "scan state not cleared after a result")

endmodule
